/* rtl/page_mapping_table_unit_macros.svh */
// assertion macros for the page mapping table
`ifndef PAGE_MAPPING_TABLE_UNIT_MACROS_SVH
`define PAGE_MAPPING_TABLE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define PMT_ASSERT_SAME(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("pmt assertion failed");

// condition implies consequence in the next cycle
`define PMT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("pmt assertion failed");

`endif

/* rtl/pmt_pkg.sv */
// shared constants for the page mapping table
package pmt_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned PageBitsDef  = 12;
  localparam int unsigned FlagW        = 5;

  localparam int unsigned FlagItlb  = 2;
  localparam int unsigned FlagDtlb  = 3;
  localparam int unsigned FlagValid = 4;

  localparam logic [1:0] CmdMap    = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;
  localparam logic [1:0] CmdNone   = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StOverwr   = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

endpackage

/* rtl/pmt_cell.sv */
// one slot of the rotating mapping ring
module pmt_cell #(
  parameter int unsigned EntryW = 45
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [EntryW-1:0] entry_i,
  output logic [EntryW-1:0] entry_o
);

  logic [EntryW-1:0] entry_q;
  logic [EntryW-1:0] entry_d;

  always_comb begin
    entry_d = shift_i ? entry_i : entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

/* rtl/page_mapping_table_unit.sv */
// page mapping table: fully associative virtual to physical page map
//
// usage: a command word (map, lookup, remove) enters on the input channel
// (in_valid_i/in_ready_o) and exactly one result word leaves on the output
// channel (out_valid_o/out_ready_i). the slots sit in a ring of cells that
// rotates one slot per cycle past a single compare point.
// a command takes two full turns of the ring: the first finds the lowest
// matching valid slot and the highest free slot, the second writes the
// updated entry back as it passes. the result is registered in the done
// state once the output register is free; a new word is taken only when
// the unit is idle again, after the previous command has left done.
// a finished result waits in the output register while the next command
// is already taken; when the receiver stalls with a result still held,
// the ring finishes its turns and then waits.
// reset clears every slot to invalid and empties the output register.
module page_mapping_table_unit #(
  parameter int unsigned SLOT_COUNT = pmt_pkg::SlotCountDef,
  parameter int unsigned PAGE_BITS  = pmt_pkg::PageBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [3:0]  map_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_page_o,
  output logic        hit_itlb_o,
  output logic        hit_dtlb_o,
  output logic        itlb_write_o,
  output logic        dtlb_write_o,
  output logic        dtlb_invalidate_o,
  output logic [31:0] tlb_virt_page_o,
  output logic [31:0] tlb_phys_word_o
);

  localparam int unsigned PW     = 32 - PAGE_BITS;
  localparam int unsigned FW     = pmt_pkg::FlagW;
  localparam int unsigned EntryW = 2 * PW + FW;
  localparam int unsigned CW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CW-1:0] LastIdx = CW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [1:0]    cmd_q;
  logic [PW-1:0] vpage_q, ppage_q;
  logic [3:0]    req_q;

  logic          hit_q, free_q;
  logic [CW-1:0] hit_idx_q, free_idx_q;
  logic [PW-1:0] hit_ppage_q;
  logic [FW-1:0] hit_flags_q;

  logic [EntryW-1:0] ring [SLOT_COUNT];
  logic [EntryW-1:0] head, feedback;
  logic              shift;
  logic [PW-1:0]     head_vpage;
  logic [FW-1:0]     head_flags;
  logic              head_match, last;

  // result of the command from the scan
  logic              r_wr_en;
  logic [CW-1:0]     r_wr_idx;
  logic [EntryW-1:0] r_wr_entry;
  logic [2:0]        r_status;
  logic [31:0]       r_found, r_tv, r_tp;
  logic              r_hi, r_hd, r_iw, r_dw, r_inv;
  logic [FW-1:0]     nf;

  assign head       = ring[0];
  assign head_vpage = head[EntryW-1 -: PW];
  assign head_flags = head[FW-1:0];
  assign head_match = head_flags[pmt_pkg::FlagValid] && (head_vpage == vpage_q);
  assign shift      = (st_q == S_SCAN) || (st_q == S_WRITE);
  assign last       = (cnt_q == LastIdx);
  assign feedback   = ((st_q == S_WRITE) && r_wr_en && (cnt_q == r_wr_idx)) ?
                      r_wr_entry : head;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_ring
    logic [EntryW-1:0] nxt;
    if (g == SLOT_COUNT - 1) begin : g_tail
      assign nxt = feedback;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    pmt_cell #(.EntryW(EntryW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (ring[g])
    );
  end

  always_comb begin
    r_wr_en    = 1'b0;
    r_wr_idx   = hit_idx_q;
    r_wr_entry = '0;
    r_status   = pmt_pkg::StOk;
    r_found    = '0;
    r_tv       = '0;
    r_tp       = '0;
    r_hi       = 1'b0;
    r_hd       = 1'b0;
    r_iw       = 1'b0;
    r_dw       = 1'b0;
    r_inv      = 1'b0;
    nf         = '0;
    case (cmd_q)
      pmt_pkg::CmdMap: begin
        if (hit_q) begin
          if (hit_ppage_q == ppage_q) begin
            nf       = hit_flags_q | {1'b0, req_q};
            r_status = pmt_pkg::StUpdated;
          end else begin
            nf       = {1'b1, req_q};
            r_status = pmt_pkg::StOverwr;
          end
          r_wr_en = 1'b1;
        end else if (free_q) begin
          nf       = {1'b1, req_q};
          r_wr_en  = 1'b1;
          r_wr_idx = free_idx_q;
          r_status = pmt_pkg::StOk;
        end else begin
          r_status = pmt_pkg::StFull;
        end
        r_wr_entry = {vpage_q, ppage_q, nf};
        if (r_wr_en) begin
          r_tv = {vpage_q, {PAGE_BITS{1'b0}}};
          r_tp = {ppage_q, {PAGE_BITS{1'b0}}} | {30'd0, req_q[1:0]};
          r_iw = nf[pmt_pkg::FlagItlb];
          r_dw = nf[pmt_pkg::FlagDtlb];
        end
      end
      pmt_pkg::CmdLookup: begin
        if (hit_q) begin
          r_found = {hit_ppage_q, {PAGE_BITS{1'b0}}};
          r_hi    = hit_flags_q[pmt_pkg::FlagItlb];
          r_hd    = hit_flags_q[pmt_pkg::FlagDtlb];
        end else begin
          r_status = pmt_pkg::StNotFound;
        end
      end
      pmt_pkg::CmdRemove: begin
        if (hit_q) begin
          nf                     = hit_flags_q;
          nf[pmt_pkg::FlagValid] = 1'b0;
          r_wr_en    = 1'b1;
          r_wr_entry = {vpage_q, hit_ppage_q, nf};
          r_inv      = 1'b1;
          r_tv       = {vpage_q, {PAGE_BITS{1'b0}}};
        end else begin
          r_status = pmt_pkg::StNotFound;
        end
      end
      default: begin
      end
    endcase
  end

  logic out_free;
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d  = S_SCAN;
          cnt_d = '0;
        end
      end
      S_SCAN: begin
        cnt_d = last ? '0 : cnt_q + 1'b1;
        if (last) begin
          st_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cnt_d = last ? '0 : cnt_q + 1'b1;
        if (last) begin
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d  = S_IDLE;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (in_valid_i && in_ready_o) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (st_q == S_SCAN) begin
        if (head_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!head_flags[pmt_pkg::FlagValid]) begin
          free_q <= 1'b1;
        end
      end
      if ((st_q == S_DONE) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      vpage_q <= virt_addr_i[31:PAGE_BITS];
      ppage_q <= phys_addr_i[31:PAGE_BITS];
      req_q   <= map_flags_i;
    end
    if (st_q == S_SCAN) begin
      if (head_match && !hit_q) begin
        hit_idx_q   <= cnt_q;
        hit_ppage_q <= head[FW +: PW];
        hit_flags_q <= head_flags;
      end
      if (!head_flags[pmt_pkg::FlagValid]) begin
        free_idx_q <= cnt_q;
      end
    end
    if ((st_q == S_DONE) && out_free) begin
      status_o          <= r_status;
      found_page_o      <= r_found;
      hit_itlb_o        <= r_hi;
      hit_dtlb_o        <= r_hd;
      itlb_write_o      <= r_iw;
      dtlb_write_o      <= r_dw;
      dtlb_invalidate_o <= r_inv;
      tlb_virt_page_o   <= r_tv;
      tlb_phys_word_o   <= r_tp;
    end
  end

`include "page_mapping_table_unit_macros.svh"

  `PMT_ASSERT_SAME(a_idle_cnt, clk_i, rst_ni, st_q == S_IDLE, cnt_q == '0)
  `PMT_ASSERT_NEXT(a_write_done, clk_i, rst_ni, (st_q == S_WRITE) && last, st_q == S_DONE)
  `PMT_ASSERT_SAME(a_inv_excl, clk_i, rst_ni, out_valid_o && dtlb_invalidate_o,
                   !itlb_write_o && !dtlb_write_o)

endmodule
